>>> hdl/acp_pkg.sv
// Shared types and constants for the audio chunk pacer.
package acp_pkg;

	// Time and field widths
	localparam int TimeBits   = 48;
	localparam int NowW       = 48;
	localparam int RenderW    = 24;
	localparam int WaitW      = 24;
	localparam int CountW     = 32;
	localparam int LoadW      = 16;
	localparam int RateW      = 19;
	localparam int FramesW    = 16;
	localparam int PeriodW    = 24;
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = 19;

	// Divider sizing: dividend holds frames * 1e6, divisor holds the rate or the period
	localparam int DivW       = 36;
	localparam int DsrW       = 24;
	localparam int CntW       = $clog2(DivW + 1);

	localparam logic [19:0]        UsPerSec     = 20'd1000000;
	localparam logic [6:0]         PctScale     = 7'd100;
	localparam logic [RateW-1:0]   RateDefault  = 19'd22050;
	localparam logic [FramesW-1:0] ChunkDefault = 16'd512;
	localparam logic [WaitW-1:0]   Max24        = {WaitW{1'b1}};
	localparam logic [LoadW-1:0]   Max16        = {LoadW{1'b1}};

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_SAMPLE_RATE,
		REG_CHUNK_FRAMES,
		REG_FILE_SINK
	} reg_idx_t;

	// Item operations
	typedef enum logic {
		OP_START,
		OP_WAIT
	} op_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PMUL,
		ST_LMUL,
		ST_DIV,
		ST_PSTORE,
		ST_LSTORE,
		ST_CMP,
		ST_DECIDE,
		ST_ADVANCE,
		ST_RESULT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic load_period_div;
		logic load_load_div;
		logic clear_load;
		logic div_step;
		logic store_period;
		logic store_load;
		logic compare;
		logic decide;
		logic advance;
		logic publish;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic in_operation;
		logic operation;
		logic file_sink;
		logic period_zero;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

>>> hdl/acp_if.sv
// Channel interfaces: input items, result words and configuration writes.
interface acp_item_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [acp_pkg::NowW-1:0]      now_time;
	logic [acp_pkg::RenderW-1:0]   render_time;

	modport source (output valid, output operation, output now_time, output render_time,
		input ready);
	modport sink (input valid, input operation, input now_time, input render_time,
		output ready);
endinterface

interface acp_result_if;
	logic                          valid;
	logic                          ready;
	logic [acp_pkg::WaitW-1:0]     wait_time;
	logic                          late_flag;
	logic                          resync_flag;
	logic [acp_pkg::CountW-1:0]    late_total;
	logic [acp_pkg::CountW-1:0]    resync_total;
	logic [acp_pkg::LoadW-1:0]     load_percent;

	modport source (output valid, output wait_time, output late_flag, output resync_flag,
		output late_total, output resync_total, output load_percent, input ready);
	modport sink (input valid, input wait_time, input late_flag, input resync_flag,
		input late_total, input resync_total, input load_percent, output ready);
endinterface

interface acp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [acp_pkg::CfgIdxW-1:0]   index;
	logic [acp_pkg::CfgDataW-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/acp_ctrl.sv
// Sequencing state machine for the audio chunk pacer.
module acp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  acp_pkg::status_t status,
	output acp_pkg::cmd_t    cmd
);

	acp_pkg::state_t state_q;
	acp_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			acp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = status.in_operation ? acp_pkg::ST_LMUL : acp_pkg::ST_PMUL;
				end
			end
			acp_pkg::ST_PMUL: begin
				cmd.load_period_div = 1'b1;
				state_d = acp_pkg::ST_DIV;
			end
			acp_pkg::ST_LMUL: begin
				if (status.period_zero) begin
					cmd.clear_load = 1'b1;
					state_d = status.file_sink ? acp_pkg::ST_RESULT : acp_pkg::ST_CMP;
				end else begin
					cmd.load_load_div = 1'b1;
					state_d = acp_pkg::ST_DIV;
				end
			end
			acp_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = status.operation ? acp_pkg::ST_LSTORE : acp_pkg::ST_PSTORE;
				end
			end
			acp_pkg::ST_PSTORE: begin
				cmd.store_period = 1'b1;
				state_d = acp_pkg::ST_ADVANCE;
			end
			acp_pkg::ST_LSTORE: begin
				cmd.store_load = 1'b1;
				state_d = status.file_sink ? acp_pkg::ST_RESULT : acp_pkg::ST_CMP;
			end
			acp_pkg::ST_CMP: begin
				cmd.compare = 1'b1;
				state_d = acp_pkg::ST_DECIDE;
			end
			acp_pkg::ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = acp_pkg::ST_ADVANCE;
			end
			acp_pkg::ST_ADVANCE: begin
				cmd.advance = 1'b1;
				state_d = acp_pkg::ST_RESULT;
			end
			acp_pkg::ST_RESULT: begin
				if (status.out_free) begin
					cmd.publish = 1'b1;
					state_d = acp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = acp_pkg::ST_IDLE;
			end
		endcase
	end

	// An accepted word always starts work
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != acp_pkg::ST_IDLE)
		else $error("accepted word did not start work");

	// Publishing a result returns to idle
	a_publish_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> state_q == acp_pkg::ST_IDLE)
		else $error("publish did not return to idle");

	// A blocked result holds its state
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == acp_pkg::ST_RESULT && !status.out_free |=> state_q == acp_pkg::ST_RESULT)
		else $error("result dropped while output busy");

endmodule

>>> hdl/acp_dp.sv
// Datapath: configuration, shared restoring divider, deadline and counters.
module acp_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  acp_pkg::cmd_t               cmd,
	output acp_pkg::status_t            status,
	input  logic                        operation,
	input  logic [acp_pkg::NowW-1:0]    now_time,
	input  logic [acp_pkg::RenderW-1:0] render_time,
	acp_cfg_if.sink                     cfg,
	acp_result_if.source                result
);

	localparam int TB = acp_pkg::TimeBits;

	// Configuration
	logic [acp_pkg::RateW-1:0]   rate_q;
	logic [acp_pkg::FramesW-1:0] frames_q;
	logic                        file_q;

	// Captured item
	logic                        op_q;
	logic [TB-1:0]               now_q;
	logic [acp_pkg::RenderW-1:0] render_q;

	// Pacing state
	logic [acp_pkg::PeriodW-1:0] period_q;
	logic [TB-1:0]               deadline_q;
	logic [acp_pkg::CountW-1:0]  late_cnt_q;
	logic [acp_pkg::CountW-1:0]  resync_cnt_q;
	logic                        use_now_q;

	// Working results
	logic [TB:0]                 diff_q;
	logic [TB-1:0]               lateness_q;
	logic [acp_pkg::WaitW-1:0]   wait_q;
	logic                        late_q;
	logic                        resync_q;
	logic [acp_pkg::LoadW-1:0]   load_q;

	// Divider
	logic [acp_pkg::DsrW-1:0]    rem_q;
	logic [acp_pkg::DivW-1:0]    quo_q;
	logic [acp_pkg::DsrW-1:0]    dsr_q;
	logic [acp_pkg::CntW-1:0]    cnt_q;

	// Output register
	logic                        out_valid_q;
	logic [acp_pkg::WaitW-1:0]   out_wait_q;
	logic                        out_late_q;
	logic                        out_resync_q;
	logic [acp_pkg::CountW-1:0]  out_late_tot_q;
	logic [acp_pkg::CountW-1:0]  out_resync_tot_q;
	logic [acp_pkg::LoadW-1:0]   out_load_q;

	logic [acp_pkg::RateW-1:0]   rate_eff;
	logic [acp_pkg::FramesW-1:0] frames_eff;
	logic [acp_pkg::DivW-1:0]    period_num;
	logic [30:0]                 load_prod;
	logic [acp_pkg::DivW-1:0]    load_num;
	logic [acp_pkg::DsrW:0]      shifted;
	logic [acp_pkg::DsrW+1:0]    trial;
	logic                        trial_ge;
	logic [acp_pkg::PeriodW-1:0] period_sat;
	logic [acp_pkg::LoadW-1:0]   load_sat;

	// Substitute defaults for zero settings
	assign rate_eff   = (rate_q == '0) ? acp_pkg::RateDefault : rate_q;
	assign frames_eff = (frames_q == '0) ? acp_pkg::ChunkDefault : frames_q;

	// Dividends: frames * 1e6, and render * 100 plus half a period for rounding
	assign period_num = acp_pkg::DivW'(frames_eff) * acp_pkg::DivW'(acp_pkg::UsPerSec);
	assign load_prod  = 31'(render_q) * 31'(acp_pkg::PctScale);
	assign load_num   = acp_pkg::DivW'(load_prod) + acp_pkg::DivW'(period_q[acp_pkg::PeriodW-1:1]);

	// One restoring step per cycle
	assign shifted  = {rem_q, quo_q[acp_pkg::DivW-1]};
	assign trial    = {1'b0, shifted} - {2'b00, dsr_q};
	assign trial_ge = ~trial[acp_pkg::DsrW+1];

	// Saturate quotients; a zero load quotient with a nonzero render time becomes 1
	assign period_sat = (quo_q[acp_pkg::DivW-1:acp_pkg::PeriodW] != '0) ?
		acp_pkg::Max24 : quo_q[acp_pkg::PeriodW-1:0];
	always_comb begin
		if (quo_q > acp_pkg::DivW'(acp_pkg::Max16)) begin
			load_sat = acp_pkg::Max16;
		end else if (quo_q == '0 && render_q != '0) begin
			load_sat = acp_pkg::LoadW'(1);
		end else begin
			load_sat = quo_q[acp_pkg::LoadW-1:0];
		end
	end

	assign status.in_operation = operation;
	assign status.operation    = op_q;
	assign status.file_sink    = file_q;
	assign status.period_zero  = (period_q == '0);
	assign status.div_last     = (cnt_q == acp_pkg::CntW'(1));
	assign status.out_free     = ~out_valid_q | result.ready;

	assign cfg.ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= acp_pkg::RateDefault;
			frames_q <= acp_pkg::ChunkDefault;
			file_q   <= 1'b0;
		end else if (cfg.valid) begin
			case (acp_pkg::reg_idx_t'(cfg.index))
				acp_pkg::REG_SAMPLE_RATE:  rate_q   <= cfg.data[acp_pkg::RateW-1:0];
				acp_pkg::REG_CHUNK_FRAMES: frames_q <= cfg.data[acp_pkg::FramesW-1:0];
				acp_pkg::REG_FILE_SINK:    file_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Pacing state, counters and divider count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= '0;
			deadline_q   <= '0;
			late_cnt_q   <= '0;
			resync_cnt_q <= '0;
			cnt_q        <= '0;
		end else begin
			if (cmd.load_period_div || cmd.load_load_div) begin
				cnt_q <= acp_pkg::CntW'(acp_pkg::DivW);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - acp_pkg::CntW'(1);
			end
			if (cmd.store_period) begin
				period_q <= period_sat;
			end
			if (cmd.decide && diff_q[TB]) begin
				late_cnt_q <= late_cnt_q + acp_pkg::CountW'(1);
				if (lateness_q > TB'(period_q)) begin
					resync_cnt_q <= resync_cnt_q + acp_pkg::CountW'(1);
				end
			end
			if (cmd.advance) begin
				deadline_q <= (use_now_q ? now_q : deadline_q) + TB'(period_q);
			end
		end
	end

	// Capture item, run divider, compare and decide
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= operation;
			now_q    <= TB'(now_time);
			render_q <= render_time;
			wait_q   <= '0;
			late_q   <= 1'b0;
			resync_q <= 1'b0;
			load_q   <= '0;
		end
		if (cmd.load_period_div) begin
			rem_q <= '0;
			quo_q <= period_num;
			dsr_q <= acp_pkg::DsrW'(rate_eff);
		end else if (cmd.load_load_div) begin
			rem_q <= '0;
			quo_q <= load_num;
			dsr_q <= period_q;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial[acp_pkg::DsrW-1:0] : shifted[acp_pkg::DsrW-1:0];
			quo_q <= {quo_q[acp_pkg::DivW-2:0], trial_ge};
		end
		if (cmd.clear_load) begin
			load_q <= '0;
		end else if (cmd.store_load) begin
			load_q <= load_sat;
		end
		if (cmd.store_period) begin
			use_now_q <= 1'b1;
		end
		if (cmd.compare) begin
			diff_q     <= {1'b0, deadline_q} - {1'b0, now_q};
			lateness_q <= now_q - deadline_q;
		end
		if (cmd.decide) begin
			if (!diff_q[TB]) begin
				wait_q    <= (diff_q[TB-1:0] > TB'(acp_pkg::Max24)) ?
					acp_pkg::Max24 : diff_q[acp_pkg::WaitW-1:0];
				use_now_q <= 1'b0;
			end else begin
				late_q    <= 1'b1;
				resync_q  <= (lateness_q > TB'(period_q));
				use_now_q <= (lateness_q > TB'(period_q));
			end
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_wait_q       <= wait_q;
			out_late_q       <= late_q;
			out_resync_q     <= resync_q;
			out_late_tot_q   <= late_cnt_q;
			out_resync_tot_q <= resync_cnt_q;
			out_load_q       <= load_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.wait_time    = out_wait_q;
	assign result.late_flag    = out_late_q;
	assign result.resync_flag  = out_resync_q;
	assign result.late_total   = out_late_tot_q;
	assign result.resync_total = out_resync_tot_q;
	assign result.load_percent = out_load_q;

	// A resync word is always a late word
	a_resync_is_late: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.resync_flag |-> result.late_flag)
		else $error("resync flagged without late");

	// Late count moves by one at a time
	a_late_step: assert property (@(posedge clk) disable iff (!arst_n)
		late_cnt_q != $past(late_cnt_q) |-> late_cnt_q == $past(late_cnt_q) + acp_pkg::CountW'(1))
		else $error("late count jumped");

	// Partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < dsr_q)
		else $error("divider remainder out of range");

endmodule

>>> hdl/audio_chunk_pacer.sv
// Audio chunk pacer: top level joining the controller and the datapath.
//
// Channels: item (operation, now_time, render_time) in, result (wait_time,
// late_flag, resync_flag, late_total, resync_total, load_percent) out, and
// cfg, a register write port (index 0 sample_rate, 1 chunk_frames,
// 2 file_sink) that is always ready. Every accepted word yields one result.
//
// Sequence: one word at a time. Both the chunk period (start word) and the
// load percentage (wait word) come from the shared one-bit-per-cycle
// restoring divider (36 steps). A wait word then compares and decides; in
// file mode it skips those steps, and a wait word before any start skips the
// divider too. item.ready is high only while idle, so the next word can be
// taken in the cycle after the result is published.
//
// Reset clears the deadline, period and counters and loads the register
// defaults (22050, 512, device sink). A finished result sits in an output
// register; a new word may be accepted while it waits, but the next result
// holds inside until the receiver takes the pending one.
module audio_chunk_pacer (
	input  logic          clk,
	input  logic          arst_n,
	acp_item_if.sink      item,
	acp_result_if.source  result,
	acp_cfg_if.sink       cfg
);

	acp_pkg::cmd_t    cmd;
	acp_pkg::status_t status;
	logic             in_ready;

	assign item.ready = in_ready;

	acp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	acp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.operation   (item.operation),
		.now_time    (item.now_time),
		.render_time (item.render_time),
		.cfg         (cfg),
		.result      (result)
	);

endmodule
